// ===== rtl/core/cell_balance_decision_macros.svh =====
// ----------------------------------------------------------------------------
// Cell balance decision assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CELL_BALANCE_DECISION_MACROS_SVH
`define CELL_BALANCE_DECISION_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define BAL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition that must never hold in two consecutive cycles.
`define BAL_ASSERT_PULSE(label, sig, msg) \
  `BAL_ASSERT(label, (sig) |=> !(sig), msg)

`endif

// ===== rtl/core/bal_pkg.sv =====
// ----------------------------------------------------------------------------
// Cell balance package
// Widths, constants, register codes and shared types of the balance block.
// ----------------------------------------------------------------------------
package bal_pkg;

  // Number of cells in one set.
  localparam int NUM_CELLS = 15;

  localparam int VOLT_W = 16;
  localparam int MASK_W = 15;
  localparam int OUT_W  = 16;

  // Index over the cells of a set, 0 .. NUM_CELLS-1.
  localparam int CNT_W = $clog2(NUM_CELLS);

  // Sum of excesses, then the sum scaled by ten.
  localparam int SUM_W  = VOLT_W + $clog2(NUM_CELLS);
  localparam int PROD_W = SUM_W + 4;

  // Constant divisor of the imbalance figure. It always carries a factor of
  // four, which is shifted off before the reciprocal multiplication.
  localparam int DIVISOR   = 12 * (NUM_CELLS - 1);
  localparam int DIV_SHIFT = 2;
  localparam int DIV_BASE  = DIVISOR >> DIV_SHIFT;
  localparam int DIV_IN_W  = PROD_W - DIV_SHIFT;

  // Reciprocal of the remaining divisor, rounded up. The scale is large
  // enough that the truncated product equals the exact quotient for every
  // dividend that fits in DIV_IN_W bits.
  localparam int RECIP_SHIFT = DIV_IN_W + $clog2(DIV_BASE);
  localparam int RECIP_W     = DIV_IN_W + 1;
  localparam int MUL_W       = DIV_IN_W + RECIP_W;
  localparam int QUOT_W      = MUL_W - RECIP_SHIFT;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(
    ((longint'(1) << RECIP_SHIFT) + longint'(DIV_BASE) - 1) / longint'(DIV_BASE));

  // Register file codes.
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_DELTA   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_MIN_V   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_CEILING = 2'd2;

  localparam logic [VOLT_W-1:0] DELTA_RESET   = 16'd250;
  localparam logic [VOLT_W-1:0] MIN_V_RESET   = 16'd36000;
  localparam logic [VOLT_W-1:0] CEILING_RESET = 16'd42000;

  // Control of the evaluation cell at the head of the chain.
  typedef struct packed {
    logic clr;
    logic step;
  } eval_ctl_t;

endpackage

// ===== rtl/core/cell_balance_decision.sv =====
// ----------------------------------------------------------------------------
// Cell balance decision
// Collects a set of cell voltages and reports the discharge mask, the lowest
// voltage and the imbalance figure of the set.
// ----------------------------------------------------------------------------
// Usage:
// One cell voltage word is taken per cycle when start is high and busy is
// low, cells of a set in order. The lowest search starts from the ceiling
// register as the first cell of a set arrives. No result follows the cells
// before the last one of a set, and these are taken back to back.
// After the last cell, busy stays high while the cell chain shifts its
// NUM_CELLS voltages through the evaluation cell (one per cycle), then the
// sequencer starts the reciprocal divider on the scaled sum (S_DIV_START)
// and takes its quotient into the result registers (S_DIV).
// The result word appears with out_valid for one cycle once the divider is
// done; busy is already low in that cycle, so the next set may begin.
// The receiver cannot stall; every result must be taken on its strobe.
// Reset clears the cell count, the control state and loads the register
// reset values; the chain contents need no clearing since every entry is
// written before it is read. Registers are to be written over the APB port
// only while no set is under evaluation; the block does not enforce this.
// ----------------------------------------------------------------------------
`include "cell_balance_decision_macros.svh"

module cell_balance_decision (
  input  logic                       clk,
  input  logic                       rst_n,
  // Input channel
  input  logic                       start,
  output logic                       busy,
  input  logic [bal_pkg::VOLT_W-1:0] in_cell_voltage,
  // Result channel
  output logic                       out_valid,
  output logic [bal_pkg::MASK_W-1:0] out_balance_mask,
  output logic [bal_pkg::OUT_W-1:0]  out_lowest_voltage,
  output logic [bal_pkg::OUT_W-1:0]  out_imbalance_hundredths,
  // Configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [3:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import bal_pkg::*;

  typedef enum logic [1:0] {
    S_LOAD,
    S_PASS,
    S_DIV_START,
    S_DIV
  } state_t;

  state_t             state_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [VOLT_W-1:0]  lowest_r;
  logic [VOLT_W-1:0]  delta_r;
  logic [VOLT_W-1:0]  min_v_r;
  logic [VOLT_W-1:0]  ceiling_r;
  logic               out_valid_r;
  logic [MASK_W-1:0]  out_mask_r;
  logic [OUT_W-1:0]   out_lowest_r;
  logic [OUT_W-1:0]   out_imb_r;

  logic               accept;
  logic               last_cell;
  logic               cfg_wr;
  logic [REG_IDX_W-1:0] reg_idx;
  logic [VOLT_W-1:0]  lowest_base;
  logic [VOLT_W-1:0]  lowest_nxt;
  logic               chain_shift;
  logic [VOLT_W-1:0]  chain_tail;
  logic [VOLT_W-1:0]  chain_q [NUM_CELLS];
  eval_ctl_t          eval_ctl;
  logic [PROD_W-1:0]  scaled_sum;
  logic [MASK_W-1:0]  eval_mask;
  logic               div_done;
  logic [OUT_W-1:0]   div_quot;

  assign busy      = (state_r != S_LOAD);
  assign accept    = start && !busy;
  assign last_cell = (cnt_r == CNT_W'(NUM_CELLS - 1));

  // Register port: always ready, word addressed.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delta_r   <= DELTA_RESET;
      min_v_r   <= MIN_V_RESET;
      ceiling_r <= CEILING_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_DELTA:   delta_r   <= pwdata[VOLT_W-1:0];
        REG_MIN_V:   min_v_r   <= pwdata[VOLT_W-1:0];
        REG_CEILING: ceiling_r <= pwdata[VOLT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DELTA:   prdata = 32'(delta_r);
      REG_MIN_V:   prdata = 32'(min_v_r);
      REG_CEILING: prdata = 32'(ceiling_r);
      default:     prdata = '0;
    endcase
  end

  // Running lowest, restarted from the ceiling with the first cell of a set.
  assign lowest_base = (cnt_r == '0) ? ceiling_r : lowest_r;
  assign lowest_nxt  = (in_cell_voltage < lowest_base) ? in_cell_voltage : lowest_base;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lowest_r <= CEILING_RESET;
    end else if (accept) begin
      lowest_r <= lowest_nxt;
    end
  end

  // Cell chain: voltages enter at the tail and leave at the head. During
  // the pass the head word goes back into the tail.
  assign chain_shift = accept || (state_r == S_PASS);
  assign chain_tail  = busy ? chain_q[0] : in_cell_voltage;

  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_chain
    if (g == NUM_CELLS - 1) begin : g_tail
      bal_cell u_cell (
        .clk   (clk),
        .shift (chain_shift),
        .d     (chain_tail),
        .q     (chain_q[g])
      );
    end else begin : g_mid
      bal_cell u_cell (
        .clk   (clk),
        .shift (chain_shift),
        .d     (chain_q[g+1]),
        .q     (chain_q[g])
      );
    end
  end

  // Evaluation at the chain head.
  assign eval_ctl.clr  = accept && last_cell;
  assign eval_ctl.step = (state_r == S_PASS);

  bal_eval u_eval (
    .clk        (clk),
    .ctl        (eval_ctl),
    .head       (chain_q[0]),
    .lowest     (lowest_r),
    .delta      (delta_r),
    .min_v      (min_v_r),
    .scaled_sum (scaled_sum),
    .mask       (eval_mask)
  );

  bal_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == S_DIV_START),
    .dividend (scaled_sum),
    .done     (div_done),
    .quotient (div_quot)
  );

  // Sequencer with the result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_LOAD: begin
          if (accept) begin
            if (last_cell) begin
              cnt_r   <= '0;
              state_r <= S_PASS;
            end else begin
              cnt_r <= cnt_r + 1'b1;
            end
          end
        end
        S_PASS: begin
          if (last_cell) begin
            cnt_r   <= '0;
            state_r <= S_DIV_START;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_DIV_START: begin
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            out_valid_r  <= 1'b1;
            out_mask_r   <= eval_mask;
            out_lowest_r <= lowest_r;
            out_imb_r    <= div_quot;
            state_r      <= S_LOAD;
          end
        end
        default: begin
          state_r <= S_LOAD;
        end
      endcase
    end
  end

  assign out_valid                = out_valid_r;
  assign out_balance_mask         = out_mask_r;
  assign out_lowest_voltage       = out_lowest_r;
  assign out_imbalance_hundredths = out_imb_r;

  // A result word is a single-cycle strobe.
  `BAL_ASSERT_PULSE(a_out_pulse, out_valid, "result strobe held for two cycles")
  // A result only follows the end of a division.
  `BAL_ASSERT(a_out_after_div, out_valid |-> $past(state_r == S_DIV && div_done),
              "result strobe without a finished division")
  // A taken cell never coincides with a result in the following cycle.
  `BAL_ASSERT(a_accept_no_out, accept |=> !out_valid,
              "result strobe right after a taken cell")
  // The divider only finishes while the sequencer waits for it.
  `BAL_ASSERT(a_div_done_state, div_done |-> (state_r == S_DIV),
              "divider finished outside the wait state")

endmodule

// ===== rtl/core/bal_cell.sv =====
// ----------------------------------------------------------------------------
// Cell balance chain cell
// Holds one cell voltage and passes it to its neighbor on each shift.
// ----------------------------------------------------------------------------
module bal_cell (
  input  logic                      clk,
  input  logic                      shift,
  input  logic [bal_pkg::VOLT_W-1:0] d,
  output logic [bal_pkg::VOLT_W-1:0] q
);
  import bal_pkg::*;

  logic [VOLT_W-1:0] volt_r;

  // Payload only, so no reset is needed.
  always_ff @(posedge clk) begin
    if (shift) begin
      volt_r <= d;
    end
  end

  assign q = volt_r;

endmodule

// ===== rtl/core/bal_eval.sv =====
// ----------------------------------------------------------------------------
// Cell balance evaluation cell
// Takes the voltage leaving the chain head, sums the excesses and builds the
// discharge mask one cell per cycle.
// ----------------------------------------------------------------------------
module bal_eval (
  input  logic                       clk,
  input  bal_pkg::eval_ctl_t         ctl,
  input  logic [bal_pkg::VOLT_W-1:0] head,
  input  logic [bal_pkg::VOLT_W-1:0] lowest,
  input  logic [bal_pkg::VOLT_W-1:0] delta,
  input  logic [bal_pkg::VOLT_W-1:0] min_v,
  output logic [bal_pkg::PROD_W-1:0] scaled_sum,
  output logic [bal_pkg::MASK_W-1:0] mask
);
  import bal_pkg::*;

  logic [SUM_W-1:0]            sum_r;
  logic [SUM_W-1:0]            sum_nxt;
  logic [NUM_CELLS-1:0]        flag_r;
  logic [NUM_CELLS-1:0]        flag_nxt;
  logic [VOLT_W-1:0]           excess;
  logic                        hit;
  logic [MASK_W+NUM_CELLS-1:0] flag_ext;

  // The head voltage never lies below the lowest of its set.
  assign excess = head - lowest;
  assign hit    = (excess > delta) && (head > min_v);

  // Cells leave in order, so a right shift that enters at the top leaves
  // bit i for cell i once the whole set has passed.
  always_comb begin
    sum_nxt  = sum_r;
    flag_nxt = flag_r;
    if (ctl.clr) begin
      sum_nxt  = '0;
      flag_nxt = '0;
    end else if (ctl.step) begin
      sum_nxt  = sum_r + SUM_W'(excess);
      flag_nxt = {hit, flag_r[NUM_CELLS-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    sum_r  <= sum_nxt;
    flag_r <= flag_nxt;
  end

  // Sum times ten as two shifted copies.
  assign scaled_sum = PROD_W'({sum_r, 3'b000}) + PROD_W'({sum_r, 1'b0});

  // All fifteen cells have a mask bit.
  assign flag_ext = {{MASK_W{1'b0}}, flag_r};
  assign mask     = flag_ext[MASK_W-1:0];

endmodule

// ===== rtl/core/bal_div.sv =====
// ----------------------------------------------------------------------------
// Cell balance divider
// Division by the constant imbalance divisor through a registered reciprocal
// multiplication, with the quotient saturated to the output width.
// ----------------------------------------------------------------------------
module bal_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [bal_pkg::PROD_W-1:0] dividend,
  output logic                       done,
  output logic [bal_pkg::OUT_W-1:0]  quotient
);
  import bal_pkg::*;

  logic [MUL_W-1:0]  mul_r;
  logic              done_r;
  logic [QUOT_W-1:0] quot_full;

  // The quotient is ready in the cycle after start.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= start;
    end
  end

  // Product of the dividend, with its factor of four removed, and the
  // scaled reciprocal of the rest of the divisor.
  always_ff @(posedge clk) begin
    if (start) begin
      mul_r <= MUL_W'(dividend[PROD_W-1:DIV_SHIFT]) * MUL_W'(RECIP);
    end
  end

  assign quot_full = mul_r[MUL_W-1:RECIP_SHIFT];

  assign done     = done_r;
  assign quotient = (|quot_full[QUOT_W-1:OUT_W]) ? {OUT_W{1'b1}} : quot_full[OUT_W-1:0];

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Cell balance decision testbench
// Feeds sets of cell voltage words through the input channel while the APB
// registers move through many settings, including writes in the middle of a
// set. A scoreboard class keeps its own copy of the set and the registers,
// predicts the mask, the lowest voltage and the imbalance word of every set,
// and checks each strobed result word field by field. Register reads are
// checked against the same copy.
// ----------------------------------------------------------------------------
module tb_top;
  import bal_pkg::*;

  // Register index that maps to no register; writes to it must be ignored.
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;
  // Cycles from the last cell of a set to its result word, with margin.
  localparam int SETTLE_CYCLES = NUM_CELLS + PROD_W + 12;
  localparam int CELL_TARGET = 1450;

  // How the voltages of one set are spread.
  typedef enum int {MIX_WIDE, MIX_NEAR, MIX_RAIL} cell_mix_t;

  // One result word of the block.
  typedef struct packed {
    logic [MASK_W-1:0] mask;
    logic [OUT_W-1:0]  lowest;
    logic [OUT_W-1:0]  imbalance;
  } balance_word_t;

  // Predicts the result word of each complete set and checks the block's words.
  class balance_scoreboard;
    logic [VOLT_W-1:0] delta;
    logic [VOLT_W-1:0] min_v;
    logic [VOLT_W-1:0] ceiling;
    logic [VOLT_W-1:0] set_cells [NUM_CELLS];
    logic [VOLT_W-1:0] set_lowest;
    int unsigned       cells_in_set;
    balance_word_t     expected_words [$];
    int unsigned       errors;
    int unsigned       words_checked;

    function new();
      delta         = DELTA_RESET;
      min_v         = MIN_V_RESET;
      ceiling       = CEILING_RESET;
      set_lowest    = CEILING_RESET;
      cells_in_set  = 0;
      errors        = 0;
      words_checked = 0;
    endfunction

    function void write_reg(logic [REG_IDX_W-1:0] idx, logic [VOLT_W-1:0] val);
      case (idx)
        REG_DELTA:   delta = val;
        REG_MIN_V:   min_v = val;
        REG_CEILING: ceiling = val;
        default: ;
      endcase
    endfunction

    function logic [VOLT_W-1:0] reg_value(logic [REG_IDX_W-1:0] idx);
      case (idx)
        REG_DELTA:   return delta;
        REG_MIN_V:   return min_v;
        default:     return ceiling;
      endcase
    endfunction

    // Takes one accepted cell word; the last cell of a set yields an expectation.
    function void note_cell(logic [VOLT_W-1:0] v);
      longint unsigned excess_sum;
      longint unsigned scaled;
      int unsigned     excess;
      balance_word_t   w;
      if (cells_in_set == 0) set_lowest = ceiling;
      if (cells_in_set < NUM_CELLS) set_cells[cells_in_set] = v;
      if (v < set_lowest) set_lowest = v;
      cells_in_set++;
      if (cells_in_set < NUM_CELLS) return;
      excess_sum = 0;
      w = '0;
      // Every cell is at or above the lowest, so the excess never wraps.
      for (int i = 0; i < NUM_CELLS; i++) begin
        excess = int'(set_cells[i]) - int'(set_lowest);
        excess_sum += excess;
        if (excess > delta && set_cells[i] > min_v && i < MASK_W) w.mask[i] = 1'b1;
      end
      scaled = (excess_sum * 10) / (12 * (NUM_CELLS - 1));
      w.imbalance = (scaled > 65535) ? 16'hFFFF : scaled[OUT_W-1:0];
      w.lowest = set_lowest;
      expected_words.push_back(w);
      cells_in_set = 0;
      set_lowest = ceiling;
    endfunction

    function void check_word(balance_word_t got);
      balance_word_t want;
      words_checked++;
      if (expected_words.size() == 0) begin
        $error("unexpected result word: mask %h lowest %0d imbalance %0d",
               got.mask, got.lowest, got.imbalance);
        errors++;
        return;
      end
      want = expected_words.pop_front();
      if (got.mask !== want.mask) begin
        $error("balance_mask: expected %h, got %h", want.mask, got.mask);
        errors++;
      end
      if (got.lowest !== want.lowest) begin
        $error("lowest_voltage: expected %0d, got %0d", want.lowest, got.lowest);
        errors++;
      end
      if (got.imbalance !== want.imbalance) begin
        $error("imbalance_hundredths: expected %0d, got %0d",
               want.imbalance, got.imbalance);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [VOLT_W-1:0] in_cell_voltage = '0;
  logic out_valid;
  logic [MASK_W-1:0] out_balance_mask;
  logic [OUT_W-1:0] out_lowest_voltage;
  logic [OUT_W-1:0] out_imbalance_hundredths;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  balance_scoreboard sb;
  int unsigned cells_sent = 0;
  int unsigned burst_left = 0;
  int unsigned settings_used = 0;

  cell_balance_decision i_dut (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .start                    (start),
    .busy                     (busy),
    .in_cell_voltage          (in_cell_voltage),
    .out_valid                (out_valid),
    .out_balance_mask         (out_balance_mask),
    .out_lowest_voltage       (out_lowest_voltage),
    .out_imbalance_hundredths (out_imbalance_hundredths),
    .psel                     (psel),
    .penable                  (penable),
    .pwrite                   (pwrite),
    .paddr                    (paddr),
    .pwdata                   (pwdata),
    .prdata                   (prdata),
    .pready                   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Every strobed result word is checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      sb.check_word({out_balance_mask, out_lowest_voltage, out_imbalance_hundredths});
    end
  end

  // Sends one cell word; the sender runs in bursts with random gaps between.
  task automatic feed_cell(input logic [VOLT_W-1:0] v);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 20);
    end
    start <= 1'b1;
    in_cell_voltage <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    burst_left--;
    cells_sent++;
    sb.note_cell(v);
  endtask

  // Holds the sender off until every expected word has come and the block is quiet.
  task automatic settle();
    start <= 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [VOLT_W-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'($urandom), val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic check_reg(input logic [REG_IDX_W-1:0] idx);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (prdata[VOLT_W-1:0] !== sb.reg_value(idx)) begin
      $error("register %0d: expected %0d, got %0d", idx, sb.reg_value(idx),
             prdata[VOLT_W-1:0]);
      sb.errors++;
    end
    @(posedge clk);
  endtask

  task automatic check_all_regs();
    check_reg(REG_DELTA);
    check_reg(REG_MIN_V);
    check_reg(REG_CEILING);
  endtask

  function automatic logic [VOLT_W-1:0] pick_cell(cell_mix_t mix, int center);
    case (mix)
      MIX_WIDE: return 16'($urandom);
      MIX_NEAR: return 16'(center + $urandom_range(0, 1023));
      default: begin
        case ($urandom_range(0, 2))
          0:       return 16'h0000;
          1:       return 16'hFFFF;
          default: return 16'($urandom);
        endcase
      end
    endcase
  endfunction

  // Register values: the rails, a random value, the reset value, or something near the cells.
  function automatic logic [VOLT_W-1:0] pick_reg_value(logic [REG_IDX_W-1:0] idx,
                                                        int center);
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom);
      3: return (idx == REG_DELTA) ? DELTA_RESET :
                (idx == REG_MIN_V) ? MIN_V_RESET : CEILING_RESET;
      default: begin
        if (idx == REG_DELTA) return 16'($urandom_range(0, 1023));
        if (idx == REG_MIN_V) return 16'(center + $urandom_range(0, 1023));
        return ($urandom_range(0, 3) == 0) ? 16'(center + $urandom_range(0, 1023))
                                           : 16'hFFFF;
      end
    endcase
  endfunction

  // One setting of the registers, then a random run of cells that may end mid-set.
  task automatic run_phase();
    int center;
    int n_cells;
    cell_mix_t mix;
    center = $urandom_range(0, 64511);
    mix = MIX_NEAR;
    settle();
    if ($urandom_range(0, 5) == 0) begin
      write_reg(REG_DELTA, '0);
      write_reg(REG_MIN_V, '0);
      write_reg(REG_CEILING, '0);
    end else if ($urandom_range(0, 4) == 0) begin
      write_reg(REG_DELTA, 16'hFFFF);
      write_reg(REG_MIN_V, 16'hFFFF);
      write_reg(REG_CEILING, 16'hFFFF);
    end else begin
      if ($urandom_range(0, 2) != 0) write_reg(REG_DELTA, pick_reg_value(REG_DELTA, center));
      if ($urandom_range(0, 2) != 0) write_reg(REG_MIN_V, pick_reg_value(REG_MIN_V, center));
      if ($urandom_range(0, 2) != 0) begin
        write_reg(REG_CEILING, pick_reg_value(REG_CEILING, center));
      end
    end
    if ($urandom_range(0, 7) == 0) write_reg(REG_UNUSED, 16'($urandom));
    check_all_regs();
    settings_used++;
    n_cells = $urandom_range(1, 75);
    repeat (n_cells) begin
      if (sb.cells_in_set == 0) begin
        case ($urandom_range(0, 5))
          0:       mix = MIX_WIDE;
          1:       mix = MIX_RAIL;
          default: mix = MIX_NEAR;
        endcase
      end
      feed_cell(pick_cell(mix, center));
    end
  endtask

  // Set with the reset registers: the minimum voltage boundary, zero and full scale.
  logic [VOLT_W-1:0] set_reset_regs [NUM_CELLS] = '{
    16'd35000, 16'd36000, 16'd36001, 16'd65535, 16'd42000,
    16'd35250, 16'd35251, 16'd50000, 16'd41999, 16'd36000,
    16'd37000, 16'd39999, 16'd0,     16'd45000, 16'd35001
  };
  // Set split by register writes: the delta boundary and the minimum voltage
  // take the new values, while the ceiling only applies from the next set.
  logic [VOLT_W-1:0] set_split [NUM_CELLS] = '{
    16'd40300, 16'd40301, 16'd40000, 16'd65535, 16'd41000,
    16'd40500, 16'd40001, 16'd42000, 16'd40299, 16'd45000,
    16'd40000, 16'd60000, 16'd40302, 16'd43210, 16'd40100
  };

  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_all_regs();
    settings_used++;

    foreach (set_reset_regs[i]) feed_cell(set_reset_regs[i]);
    for (int i = 0; i < 5; i++) feed_cell(set_split[i]);
    settle();
    write_reg(REG_DELTA, 16'd300);
    write_reg(REG_MIN_V, 16'd40000);
    write_reg(REG_CEILING, 16'd100);
    write_reg(REG_UNUSED, 16'h1234);
    check_all_regs();
    settings_used++;
    for (int i = 5; i < NUM_CELLS; i++) feed_cell(set_split[i]);

    while (cells_sent < CELL_TARGET) run_phase();
    settle();

    $display("sent %0d cell words, checked %0d result words over %0d register settings",
             cells_sent, sb.words_checked, settings_used);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #3000000;
    $display("status: fail");
    $finish;
  end

endmodule

// ===== cell_balance_decision.f =====
+incdir+rtl/core
rtl/core/bal_pkg.sv
rtl/core/bal_cell.sv
rtl/core/bal_eval.sv
rtl/core/bal_div.sv
rtl/core/cell_balance_decision.sv
test/tb_top.sv
